// ===== hdl/sadf_pkg.sv =====
// sadf_pkg: shared types and constants of the sequential signed alu
// operation codes, error codes and the add/subtract unit's control word
// no dependencies
package sadf_pkg;

    // operation codes on the func port
    localparam logic [2:0] FUNC_ADD  = 3'd0;
    localparam logic [2:0] FUNC_SUB  = 3'd1;
    localparam logic [2:0] FUNC_MUL  = 3'd2;
    localparam logic [2:0] FUNC_DIV  = 3'd3;
    localparam logic [2:0] FUNC_FACT = 3'd4;

    // error codes on the error_code port
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_FACT_NEG = 2'd1;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

    // led display mask
    localparam logic [3:0] LED_MASK = 4'hF;

    // add/subtract unit operation
    typedef enum logic {
        AS_ADD = 1'b0,
        AS_SUB = 1'b1
    } addsub_op_t;

    typedef struct packed {
        addsub_op_t op;
    } addsub_ctl_t;

endpackage

// ===== hdl/signed_alu_mul_div_factorial.sv =====
// signed_alu_mul_div_factorial: sequential signed alu, top level
// add, subtract, errors and unknown codes go from idle straight to the fix-up step;
// multiply and divide first run the shift-add/subtract loop over all DATA_WIDTH bits,
// factorial a loop up to a or the first n with n! wrapping to 0; one word in flight
// a new word is taken once the result is in the output register
// reset: asynchronous, active low; sequencer idle, no result word valid
module signed_alu_mul_div_factorial #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result,
    output logic [1:0]         error_code,
    output logic [3:0]         led_bits
);

    localparam int W    = DATA_WIDTH;
    // loop step counter holds W itself
    localparam int CntW = $clog2(DATA_WIDTH + 1);
    // factorial index: the product wraps to zero well before 4*W
    localparam int IdxW = $clog2(DATA_WIDTH) + 3;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FACT = 5'b01000,
        ST_FIX  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [W-1:0]      acc_reg, acc_next;       // sum, product, quotient, factorial
    logic [W-1:0]      mcand_reg, mcand_next;   // multiplicand or divisor magnitude
    logic [W-1:0]      q_reg, q_next;           // multiplier, dividend/quotient, bound
    logic [W-1:0]      rem_reg, rem_next;       // partial remainder
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [IdxW-1:0]   idx_reg, idx_next;
    logic              neg_reg, neg_next;       // negate in the fix-up step
    logic [1:0]        err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       result_reg, result_next;
    logic [1:0]        err_out_reg, err_out_next;

    // operands: sign-extend the 32-bit fields, then cut to the word width
    logic signed [63:0] a_ext, b_ext;
    logic [W-1:0]       a_w, b_w, a_mag, b_mag;
    logic               a_neg, b_neg, differ;

    assign a_ext  = 64'(operand_a);
    assign b_ext  = 64'(operand_b);
    assign a_w    = a_ext[W-1:0];
    assign b_w    = b_ext[W-1:0];
    assign a_neg  = a_w[W-1];
    assign b_neg  = b_w[W-1];
    assign a_mag  = a_neg ? (~a_w + W'(1)) : a_w;
    assign b_mag  = b_neg ? (~b_w + W'(1)) : b_w;
    assign differ = a_neg ^ b_neg;

    // shared add/subtract unit, one bit wider for the divide trial subtract
    logic [W:0]            ux, uy, usum;
    logic                  ucarry;
    sadf_pkg::addsub_ctl_t uctl;

    sadf_addsub #(
        .WIDTH (W + 1)
    ) u_addsub (
        .x     (ux),
        .y     (uy),
        .ctl   (uctl),
        .sum   (usum),
        .carry (ucarry)
    );

    always_comb
    begin
        ux      = '0;
        uy      = '0;
        uctl.op = sadf_pkg::AS_ADD;
        case (state_reg)
            ST_IDLE:
            begin
                // add or subtract straight from the ports
                ux = {1'b0, a_w};
                uy = {1'b0, b_w};
                if (func == sadf_pkg::FUNC_SUB)
                    uctl.op = sadf_pkg::AS_SUB;
            end
            ST_MUL:
            begin
                // accumulate the shifted multiplicand when the multiplier bit is set
                ux = {1'b0, acc_reg};
                uy = {1'b0, (q_reg[0] ? mcand_reg : '0)};
            end
            ST_DIV:
            begin
                // restoring trial subtract of the divisor
                ux      = {rem_reg, q_reg[W-1]};
                uy      = {1'b0, mcand_reg};
                uctl.op = sadf_pkg::AS_SUB;
            end
            ST_FIX:
            begin
                // apply the result sign
                if (neg_reg)
                begin
                    uy      = {1'b0, acc_reg};
                    uctl.op = sadf_pkg::AS_SUB;
                end
                else
                begin
                    ux = {1'b0, acc_reg};
                end
            end
            default:
            begin
                ux = '0;
            end
        endcase
    end

    // factorial step: narrow multiply by the running index
    logic [W+IdxW-1:0] fact_prod;
    logic              fact_go;

    assign fact_prod = acc_reg * idx_reg;
    assign fact_go   = (W'(idx_reg) <= q_reg) && (acc_reg != '0);

    // result sign-extended from the word width to the 32-bit field
    logic signed [63:0] res_ext;
    assign res_ext = 64'(signed'(usum[W-1:0]));

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        err_next       = err_reg;
        result_next    = result_reg;
        err_out_next   = err_out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = 1'b0;
                    err_next   = sadf_pkg::ERR_NONE;
                    acc_next   = '0;
                    state_next = ST_FIX;
                    case (func)
                        sadf_pkg::FUNC_ADD, sadf_pkg::FUNC_SUB:
                        begin
                            acc_next = usum[W-1:0];
                        end
                        sadf_pkg::FUNC_MUL:
                        begin
                            mcand_next = b_mag;
                            q_next     = a_mag;
                            cnt_next   = CntW'(W);
                            neg_next   = differ;
                            state_next = ST_MUL;
                        end
                        sadf_pkg::FUNC_DIV:
                        begin
                            if (b_w == '0)
                            begin
                                err_next = sadf_pkg::ERR_DIV_ZERO;
                            end
                            else
                            begin
                                rem_next   = '0;
                                mcand_next = b_mag;
                                q_next     = a_mag;
                                cnt_next   = CntW'(W);
                                neg_next   = differ;
                                state_next = ST_DIV;
                            end
                        end
                        sadf_pkg::FUNC_FACT:
                        begin
                            if (a_neg)
                            begin
                                err_next = sadf_pkg::ERR_FACT_NEG;
                            end
                            else
                            begin
                                acc_next   = W'(1);
                                idx_next   = IdxW'(1);
                                q_next     = a_w;
                                state_next = ST_FACT;
                            end
                        end
                        default:
                        begin
                            // unknown code: zero result, no error
                            acc_next = '0;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                acc_next   = usum[W-1:0];
                mcand_next = mcand_reg << 1;
                q_next     = q_reg >> 1;
                cnt_next   = cnt_reg - CntW'(1);
                if (cnt_reg == CntW'(1))
                    state_next = ST_FIX;
            end
            ST_DIV:
            begin
                rem_next = ucarry ? usum[W-1:0] : ux[W-1:0];
                q_next   = {q_reg[W-2:0], ucarry};
                acc_next = {q_reg[W-2:0], ucarry};
                cnt_next = cnt_reg - CntW'(1);
                if (cnt_reg == CntW'(1))
                    state_next = ST_FIX;
            end
            ST_FACT:
            begin
                // stop once past a or once the product has wrapped to zero
                if (fact_go)
                begin
                    acc_next = fact_prod[W-1:0];
                    idx_next = idx_reg + IdxW'(1);
                end
                else
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_next    = res_ext[31:0];
                    err_out_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        idx_reg     <= idx_next;
        neg_reg     <= neg_next;
        err_reg     <= err_next;
        result_reg  <= result_next;
        err_out_reg <= err_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign result     = result_reg;
    assign error_code = err_out_reg;
    assign led_bits   = result_reg[3:0] & sadf_pkg::LED_MASK;

    // an error word always carries a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (error_code != sadf_pkg::ERR_NONE)) |-> (result == '0))
        else $error("error word with nonzero result");

    // only defined error codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((error_code == sadf_pkg::ERR_NONE) ||
                       (error_code == sadf_pkg::ERR_FACT_NEG) ||
                       (error_code == sadf_pkg::ERR_DIV_ZERO)))
        else $error("undefined error code");

    // the block is busy in the cycle after it takes a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after accept");

    // multiply and divide loops never run with an exhausted step count
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MUL) || (state_reg == ST_DIV)) |-> (cnt_reg != '0))
        else $error("loop step count exhausted");

    // led bits follow the result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (led_bits == result[3:0]))
        else $error("led bits differ from result");

endmodule

// ===== hdl/sadf_addsub.sv =====
// sadf_addsub: shared add/subtract unit of the sequential signed alu
// one adder with carry out, used by the add, subtract, multiply, divide and fix-up steps
// depends on sadf_pkg
module sadf_addsub #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0]    x,
    input  logic [WIDTH-1:0]    y,
    input  sadf_pkg::addsub_ctl_t ctl,
    output logic [WIDTH-1:0]    sum,
    output logic                carry
);

    logic             is_sub;
    logic [WIDTH-1:0] y_op;
    logic [WIDTH:0]   total;

    assign is_sub = (ctl.op == sadf_pkg::AS_SUB);
    assign y_op   = is_sub ? ~y : y;
    // carry out is the no-borrow flag when subtracting
    assign total  = {1'b0, x} + {1'b0, y_op} + (WIDTH+1)'(is_sub);
    assign sum    = total[WIDTH-1:0];
    assign carry  = total[WIDTH];

endmodule
